// ===== hdl/wsfd_pkg.sv =====
// Shared types, codes and defaults for the WebSocket frame decoder.
package wsfd_pkg;

  // Defaults for the top-level parameters and the limit register
  localparam int unsigned OffsetWidthDef = 32;
  localparam logic [31:0] MaxPayloadRst  = 32'(16 * 1024 * 1024);

  // Result kinds
  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Action classes
  localparam logic [1:0] ACT_CLOSE  = 2'd0;
  localparam logic [1:0] ACT_PONG   = 2'd1;
  localparam logic [1:0] ACT_TEXT   = 2'd2;
  localparam logic [1:0] ACT_IGNORE = 2'd3;

  // Opcodes that select an action
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  // One result item
  typedef struct packed {
    logic [1:0]  kind;
    logic        fin_flag;
    logic [3:0]  frame_opcode;
    logic        mask_flag;
    logic [31:0] payload_len;
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic        end_of_frame;
  } wsfd_res_t;

  // Map an opcode to its action class
  function automatic logic [1:0] action_of(input logic [3:0] op);
    logic [1:0] act;
    unique case (op)
      OP_CLOSE: act = ACT_CLOSE;
      OP_PING:  act = ACT_PONG;
      OP_TEXT:  act = ACT_TEXT;
      default:  act = ACT_IGNORE;
    endcase
    return act;
  endfunction

endpackage

// ===== hdl/wsfd_if.sv =====
// Handshake channels of the frame decoder: byte in, result out, limit register write.
interface wsfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsfd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        fin_flag;
  logic [3:0]  frame_opcode;
  logic        mask_flag;
  logic [31:0] payload_len;
  logic [1:0]  action;
  logic [7:0]  data_byte;
  logic        end_of_frame;

  modport source (output valid, output kind, output fin_flag, output frame_opcode,
                  output mask_flag, output payload_len, output action,
                  output data_byte, output end_of_frame, input ready);
  modport sink   (input valid, input kind, input fin_flag, input frame_opcode,
                  input mask_flag, input payload_len, input action,
                  input data_byte, input end_of_frame, output ready);
endinterface

interface wsfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] max_payload_bytes;

  modport source (output valid, output max_payload_bytes, input ready);
  modport sink   (input valid, input max_payload_bytes, output ready);
endinterface

// ===== hdl/wsfd_parse.sv =====
// Frame header parser and payload unmasker: one byte of state update per cycle.
module wsfd_parse #(
  parameter int unsigned OFFSET_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_vld_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [31:0]         max_payload_i,
  output logic                res_vld_o,
  output wsfd_pkg::wsfd_res_t res_o
);
  import wsfd_pkg::*;

  // Parser phases
  localparam logic [2:0] PH_HDR0  = 3'd0;
  localparam logic [2:0] PH_HDR1  = 3'd1;
  localparam logic [2:0] PH_EXT16 = 3'd2;
  localparam logic [2:0] PH_EXT64 = 3'd3;
  localparam logic [2:0] PH_MASK  = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [2:0] CNT_EXT16 = 3'd2;
  localparam logic [2:0] CNT_MASK  = 3'd4;
  localparam logic [64:0] OffRange = 65'(1) << OFFSET_WIDTH;

  logic [2:0]              phase_q, phase_d;
  logic [2:0]              cnt_q, cnt_d;
  logic [63:0]             len_q, len_d;
  logic [31:0]             key_q, key_d;
  logic [OFFSET_WIDTH-1:0] off_q, off_d;
  logic [3:0]              op_q, op_d;
  logic                    fin_q, fin_d;
  logic                    masked_q, masked_d;
  logic                    halted_q, halted_d;

  logic                    after_len;
  logic                    hdr_done;
  logic                    over;
  logic                    eof;
  logic [7:0]              key_byte;
  logic [64:0]             off_inc;

  // Key byte for this payload offset; first key byte sits in the top bits
  always_comb begin
    unique case (off_q[1:0])
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  assign off_inc = 65'(off_q) + 65'd1;
  assign eof     = (off_inc == {1'b0, len_q});

  // Next state and result for one accepted byte
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    key_d     = key_q;
    off_d     = off_q;
    op_d      = op_q;
    fin_d     = fin_q;
    masked_d  = masked_q;
    halted_d  = halted_q;
    after_len = 1'b0;
    hdr_done  = 1'b0;
    over      = 1'b0;
    res_vld_o = 1'b0;
    res_o.kind         = KIND_DATA;
    res_o.data_byte    = 8'd0;
    res_o.end_of_frame = 1'b0;
    res_o.action       = 2'd0;

    if (byte_vld_i && !halted_q) begin
      unique case (phase_q)
        PH_HDR0: begin
          fin_d   = rx_byte_i[7];
          op_d    = rx_byte_i[3:0];
          phase_d = PH_HDR1;
        end
        PH_HDR1: begin
          masked_d = rx_byte_i[7];
          cnt_d    = 3'd0;
          if (rx_byte_i[6:0] == LEN_EXT16) begin
            len_d   = 64'd0;
            phase_d = PH_EXT16;
          end else if (rx_byte_i[6:0] == LEN_EXT64) begin
            len_d   = 64'd0;
            phase_d = PH_EXT64;
          end else begin
            len_d     = {57'd0, rx_byte_i[6:0]};
            after_len = 1'b1;
          end
        end
        PH_EXT16, PH_EXT64: begin
          len_d = {len_q[55:0], rx_byte_i};
          cnt_d = cnt_q + 3'd1;
          if ((phase_q == PH_EXT16 && cnt_d == CNT_EXT16) ||
              (phase_q == PH_EXT64 && cnt_d == 3'd0)) begin
            after_len = 1'b1;
          end
        end
        PH_MASK: begin
          key_d = {key_q[23:0], rx_byte_i};
          cnt_d = cnt_q + 3'd1;
          if (cnt_d == CNT_MASK) begin
            hdr_done = 1'b1;
          end
        end
        PH_DATA: begin
          res_vld_o          = 1'b1;
          res_o.kind         = KIND_DATA;
          res_o.action       = action_of(op_q);
          res_o.data_byte    = masked_q ? (rx_byte_i ^ key_byte) : rx_byte_i;
          res_o.end_of_frame = eof;
          off_d              = off_inc[OFFSET_WIDTH-1:0];
          if (eof) begin
            phase_d = PH_HDR0;
            off_d   = '0;
          end
        end
        default: begin
          phase_d = PH_HDR0;
        end
      endcase

      // Length complete: go for the key or finish the header
      if (after_len) begin
        cnt_d = 3'd0;
        key_d = 32'd0;
        if (masked_d) begin
          phase_d = PH_MASK;
        end else begin
          hdr_done = 1'b1;
        end
      end

      // Header complete: error and halt, or header result
      if (hdr_done) begin
        // Over limit: beyond the register, or beyond what the offset counter can reach
        over      = (len_d > {32'd0, max_payload_i}) || ({1'b0, len_d} > OffRange);
        res_vld_o = 1'b1;
        if (over) begin
          halted_d           = 1'b1;
          phase_d            = PH_HDR0;
          res_o.kind         = KIND_ERR;
          res_o.action       = ACT_CLOSE;
          res_o.end_of_frame = 1'b1;
        end else begin
          off_d              = '0;
          cnt_d              = 3'd0;
          res_o.kind         = KIND_HDR;
          res_o.action       = action_of(op_d);
          res_o.end_of_frame = (len_d == 64'd0);
          phase_d            = (len_d == 64'd0) ? PH_HDR0 : PH_DATA;
        end
      end
    end

    res_o.fin_flag     = fin_d;
    res_o.frame_opcode = op_d;
    res_o.mask_flag    = masked_d;
    res_o.payload_len  = (len_d[63:32] != 32'd0) ? 32'hFFFF_FFFF : len_d[31:0];
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      cnt_q    <= 3'd0;
      len_q    <= 64'd0;
      key_q    <= 32'd0;
      off_q    <= '0;
      op_q     <= 4'd0;
      fin_q    <= 1'b0;
      masked_q <= 1'b0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      key_q    <= key_d;
      off_q    <= off_d;
      op_q     <= op_d;
      fin_q    <= fin_d;
      masked_q <= masked_d;
      halted_q <= halted_d;
    end
  end

  // An error result always leaves the parser halted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o && res_o.kind == KIND_ERR |=> halted_q)
    else $error("error result without halt");

  // Once halted, no further result is produced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !res_vld_o)
    else $error("result produced while halted");

  // Payload phase only runs with a length that is not zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> len_q != 64'd0 && !halted_q)
    else $error("payload phase with empty frame");

endmodule

// ===== hdl/websocket_frame_decoder.sv =====
// Top level of the WebSocket frame decoder: limit register, parser and result buffer.
//
// Usage:
//   rx_i   : received stream, one byte per request (valid/ready).
//   res_o  : results: header complete, payload byte, or over-limit error.
//   cfg_i  : write of max_payload_bytes; always ready, write only while idle.
// Header bytes give no result; the last header byte gives the header result,
// and every payload byte gives one unmasked data result.
// Each result passes through the result register (or the skid entry) to res_o.
// Throughput: one byte per cycle while rx_i is ready; the state update is a
// combinational step between the parser registers and the result register.
// Stall: a two-entry output buffer (result register plus skid) lets rx_i keep
// taking bytes while the receiver holds ready low; rx_i ready drops once the
// skid entry is occupied.
// Reset: parser returns to the first header byte, buffers empty, limit set to
// 16 MiB. After an over-limit error the block drops all bytes until reset.
module websocket_frame_decoder #(
  parameter int unsigned OFFSET_WIDTH = wsfd_pkg::OffsetWidthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wsfd_byte_if.sink  rx_i,
  wsfd_res_if.source res_o,
  wsfd_cfg_if.sink   cfg_i
);
  import wsfd_pkg::*;

  logic [31:0] max_q;
  logic        rx_fire;
  logic        new_vld;
  wsfd_res_t   new_res;
  logic        out_vld_q, skid_vld_q;
  wsfd_res_t   out_q, skid_q;
  logic        out_free;

  // Limit register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxPayloadRst;
    end else if (cfg_i.valid) begin
      max_q <= cfg_i.max_payload_bytes;
    end
  end

  assign rx_i.ready = !skid_vld_q;
  assign rx_fire    = rx_i.valid && rx_i.ready;

  wsfd_parse #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_vld_i   (rx_fire),
    .rx_byte_i    (rx_i.rx_byte),
    .max_payload_i(max_q),
    .res_vld_o    (new_vld),
    .res_o        (new_res)
  );

  // Result register and skid entry
  assign out_free = !out_vld_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q  <= skid_vld_q || new_vld;
      skid_vld_q <= 1'b0;
    end else if (new_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_vld_q ? skid_q : new_res;
    end else if (new_vld) begin
      skid_q <= new_res;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.kind         = out_q.kind;
  assign res_o.fin_flag     = out_q.fin_flag;
  assign res_o.frame_opcode = out_q.frame_opcode;
  assign res_o.mask_flag    = out_q.mask_flag;
  assign res_o.payload_len  = out_q.payload_len;
  assign res_o.action       = out_q.action;
  assign res_o.data_byte    = out_q.data_byte;
  assign res_o.end_of_frame = out_q.end_of_frame;

  // Skid entry only holds data behind a full result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry filled while result register empty");

  // Skid entry fills only on an accepted byte against a stalled receiver
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(rx_fire) && !$past(res_o.ready))
    else $error("skid entry filled without a stalled request");

  // Skid entry drains only when the receiver takes the held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(skid_vld_q) |-> $past(res_o.ready))
    else $error("skid entry lost");

endmodule

// ===== tb/tb.sv =====
// Testbench for the WebSocket frame decoder: random frame streams checked against a predictor.
`timescale 1ns / 100ps

module tb;
  import wsfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned IDLE_SETTLE  = 4;
  localparam int unsigned END_SETTLE   = 10;
  localparam logic [63:0] OFFSET_MASK  = (64'd1 << OffsetWidthDef) - 64'd1;
  localparam logic [6:0]  LEN7_EXT16   = 7'd126;
  localparam logic [6:0]  LEN7_EXT64   = 7'd127;

  typedef enum logic [2:0] {
    ST_HDR0, ST_HDR1, ST_EXT16, ST_EXT64, ST_KEY, ST_DATA
  } parse_state_e;

  typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  wsfd_byte_if rx_if ();
  wsfd_res_if  res_if ();
  wsfd_cfg_if  cfg_if ();

  websocket_frame_decoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // Byte stream waiting to be sent, and results the decoder still owes
  logic [7:0]  stream_bytes[$];
  wsfd_res_t   frame_results_due[$];
  int unsigned bytes_queued = 0;
  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;

  // Predicted decoder state (reset values)
  parse_state_e parse_st   = ST_HDR0;
  logic [2:0]   field_cnt  = '0;
  logic [63:0]  len_acc    = '0;
  logic [31:0]  mask_key   = '0;
  logic [63:0]  data_offs  = '0;
  logic [3:0]   cur_opcode = '0;
  logic         cur_fin    = 1'b0;
  logic         cur_masked = 1'b0;
  logic         halted     = 1'b0;
  logic [31:0]  limit_reg  = MaxPayloadRst;

  function automatic logic [1:0] action_class(input logic [3:0] opc);
    logic [1:0] act;
    case (opc)
      OP_CLOSE: act = ACT_CLOSE;
      OP_PING:  act = ACT_PONG;
      OP_TEXT:  act = ACT_TEXT;
      default:  act = ACT_IGNORE;
    endcase
    return act;
  endfunction

  // Append one byte to the outgoing stream
  function automatic void add_byte(input logic [7:0] b);
    stream_bytes = {stream_bytes, b};
  endfunction

  function automatic void push_result(input logic [1:0] kind, input logic [1:0] act,
                                      input logic [7:0] data, input logic eof);
    wsfd_res_t r;
    r.kind         = kind;
    r.fin_flag     = cur_fin;
    r.frame_opcode = cur_opcode;
    r.mask_flag    = cur_masked;
    // length saturates to 32 bits
    r.payload_len  = (len_acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len_acc[31:0];
    r.action       = act;
    r.data_byte    = data;
    r.end_of_frame = eof;
    frame_results_due = {frame_results_due, r};
  endfunction

  // Header complete: limit test, then header result or error
  function automatic void close_header();
    logic over;
    over = (len_acc > {32'd0, limit_reg}) ||
           (len_acc != 0 && (len_acc - 64'd1) > OFFSET_MASK);
    if (over) begin
      halted   = 1'b1;
      parse_st = ST_HDR0;
      push_result(KIND_ERR, ACT_CLOSE, 8'h00, 1'b1);
    end else begin
      data_offs = '0;
      field_cnt = '0;
      if (len_acc == 0) begin
        parse_st = ST_HDR0;
        push_result(KIND_HDR, action_class(cur_opcode), 8'h00, 1'b1);
      end else begin
        parse_st = ST_DATA;
        push_result(KIND_HDR, action_class(cur_opcode), 8'h00, 1'b0);
      end
    end
  endfunction

  function automatic void finish_length();
    field_cnt = '0;
    mask_key  = '0;
    if (cur_masked) parse_st = ST_KEY;
    else close_header();
  endfunction

  // Advance the predicted decoder by one accepted byte
  function automatic void decode_rx_byte(input logic [7:0] b);
    logic [7:0] d;
    logic       eof;
    if (halted) return;
    case (parse_st)
      ST_HDR0: begin
        cur_fin    = b[7];
        cur_opcode = b[3:0];
        parse_st   = ST_HDR1;
      end
      ST_HDR1: begin
        cur_masked = b[7];
        len_acc    = {57'd0, b[6:0]};
        field_cnt  = '0;
        if (b[6:0] == LEN7_EXT16) begin
          len_acc  = '0;
          parse_st = ST_EXT16;
        end else if (b[6:0] == LEN7_EXT64) begin
          len_acc  = '0;
          parse_st = ST_EXT64;
        end else begin
          finish_length();
        end
      end
      ST_EXT16, ST_EXT64: begin
        len_acc   = {len_acc[55:0], b};
        field_cnt = field_cnt + 3'd1;
        if ((parse_st == ST_EXT16 && field_cnt == 3'd2) ||
            (parse_st == ST_EXT64 && field_cnt == 3'd0)) finish_length();
      end
      ST_KEY: begin
        mask_key  = {mask_key[23:0], b};
        field_cnt = field_cnt + 3'd1;
        if (field_cnt == 3'd4) close_header();
      end
      ST_DATA: begin
        d = b;
        // first key byte sits in the top of the key word
        if (cur_masked) d = b ^ mask_key[8 * (3 - data_offs[1:0]) +: 8];
        eof = (data_offs + 64'd1 == len_acc);
        push_result(KIND_DATA, action_class(cur_opcode), d, eof);
        data_offs = (data_offs + 64'd1) & OFFSET_MASK;
        if (eof) begin
          parse_st  = ST_HDR0;
          data_offs = '0;
        end
      end
      default: parse_st = ST_HDR0;
    endcase
  endfunction

  // Build one frame onto the byte stream
  function automatic void queue_frame(input logic fin, input logic [2:0] rsv,
                                      input logic [3:0] opc, input logic masked,
                                      input len_form_e form, input logic [63:0] len,
                                      input int unsigned n_data);
    logic [6:0] len7;
    len7 = (form == LEN_SHORT) ? len[6:0] : (form == LEN_EXT16) ? LEN7_EXT16 : LEN7_EXT64;
    add_byte({fin, rsv, opc});
    add_byte({masked, len7});
    bytes_queued += 2 + n_data;
    if (form == LEN_EXT16) begin
      add_byte(len[15:8]);
      add_byte(len[7:0]);
      bytes_queued += 2;
    end else if (form == LEN_EXT64) begin
      for (int i = 7; i >= 0; i--) add_byte(len[8 * i +: 8]);
      bytes_queued += 8;
    end
    if (masked) begin
      repeat (4) add_byte(8'($urandom));
      bytes_queued += 4;
    end
    repeat (n_data) add_byte(8'($urandom));
  endfunction

  // Random well-formed frame with payload length up to max_len
  function automatic void queue_random_frame(input logic [31:0] max_len);
    logic [31:0] cap;
    logic [3:0]  opc;
    len_form_e   form;
    int unsigned pick;
    pick = $urandom_range(19, 0);
    cap  = (pick == 0) ? 32'd300 : (pick < 4) ? 32'd130 : 32'd20;
    if (cap > max_len) cap = max_len;
    cap = $urandom_range(cap, 0);
    case ($urandom_range(5, 0))
      0:       opc = OP_TEXT;
      1:       opc = OP_CLOSE;
      2:       opc = OP_PING;
      3:       opc = 4'h0;
      4:       opc = 4'hA;
      default: opc = 4'($urandom);
    endcase
    pick = $urandom_range(9, 0);
    if (cap < 126) form = (pick < 7) ? LEN_SHORT : (pick < 9) ? LEN_EXT16 : LEN_EXT64;
    else           form = (pick < 7) ? LEN_EXT16 : LEN_EXT64;
    queue_frame(1'($urandom), 3'($urandom), opc, 1'($urandom), form, {32'd0, cap}, cap);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Driver: bursts of requests with random gaps between them
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) decode_rx_byte(rx_if.rx_byte);
      if (!rx_if.valid || rx_if.ready) begin
        if (gap_left != 0 || stream_bytes.size() == 0) begin
          rx_if.valid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end else begin
          rx_if.valid   <= 1'b1;
          rx_if.rx_byte <= stream_bytes.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(40, 1);
            case ($urandom_range(7, 0))
              0, 1:    gap_left = 0;
              7:       gap_left = $urandom_range(30, 10);
              default: gap_left = $urandom_range(6, 1);
            endcase
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Monitor: rotating ready pattern, re-drawn every so often
  logic [15:0] stall_pat   = 16'hFFFF;
  int unsigned pat_cycles  = 0;

  always @(posedge clk_i) begin
    wsfd_res_t want;
    if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (frame_results_due.size() == 0) begin
        $error("result with nothing expected: kind 0x%0h", res_if.kind);
        fail_count++;
      end else begin
        want = frame_results_due.pop_front();
        check_field("kind",         32'(want.kind),         32'(res_if.kind));
        check_field("fin_flag",     32'(want.fin_flag),     32'(res_if.fin_flag));
        check_field("frame_opcode", 32'(want.frame_opcode), 32'(res_if.frame_opcode));
        check_field("mask_flag",    32'(want.mask_flag),    32'(res_if.mask_flag));
        check_field("payload_len",  want.payload_len,       res_if.payload_len);
        check_field("action",       32'(want.action),       32'(res_if.action));
        check_field("data_byte",    32'(want.data_byte),    32'(res_if.data_byte));
        check_field("end_of_frame", 32'(want.end_of_frame), 32'(res_if.end_of_frame));
      end
    end
    if (pat_cycles == 50) begin
      pat_cycles = 0;
      stall_pat  = ($urandom_range(3, 0) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end else begin
      pat_cycles++;
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
    res_if.ready <= stall_pat[0];
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("websocket_frame_decoder test failed");
      $finish;
    end
  end

  // Wait until every queued byte went out and every result came back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (stream_bytes.size() != 0 || rx_if.valid || frame_results_due.size() != 0);
    repeat (IDLE_SETTLE) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [31:0] value);
    @(posedge clk_i);
    cfg_if.valid             <= 1'b1;
    cfg_if.max_payload_bytes <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    limit_reg = value;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic queue_random_bytes(input int unsigned budget, input logic [31:0] max_len);
    int unsigned start;
    start = bytes_queued;
    while (bytes_queued - start < budget) queue_random_frame(max_len);
  endtask

  // Stimulus
  initial begin
    logic [31:0] lim;
    logic [63:0] big_len;
    rx_if.valid              = 1'b0;
    rx_if.rx_byte            = 8'h00;
    cfg_if.valid             = 1'b0;
    cfg_if.max_payload_bytes = 32'd0;
    res_if.ready             = 1'b0;
    rst_ni                   = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty text, masked ping, close with payload, long forms of short lengths
    queue_frame(1'b1, 3'b000, OP_TEXT,  1'b0, LEN_SHORT, 64'd0, 0);
    queue_frame(1'b1, 3'b111, OP_PING,  1'b1, LEN_SHORT, 64'd3, 3);
    queue_frame(1'b0, 3'b000, OP_CLOSE, 1'b0, LEN_SHORT, 64'd1, 1);
    queue_frame(1'b1, 3'b010, 4'hF,     1'b0, LEN_EXT16, 64'd2, 2);
    queue_frame(1'b0, 3'b101, 4'h0,     1'b0, LEN_EXT64, 64'd0, 0);
    queue_random_bytes(400, limit_reg);
    wait_drained();

    // Zero limit: only empty frames pass
    write_limit(32'd0);
    queue_random_bytes(150, limit_reg);
    wait_drained();

    // Small limit, with a frame exactly at the limit
    write_limit($urandom_range(40, 1));
    queue_frame(1'($urandom), 3'($urandom), OP_TEXT, 1'b1, LEN_SHORT,
                {32'd0, limit_reg}, limit_reg);
    queue_random_bytes(200, limit_reg);
    wait_drained();

    write_limit(32'hFFFF_FFFF);
    queue_random_bytes(250, limit_reg);
    wait_drained();

    write_limit($urandom_range(32'hFFFF_FFFE, 300));
    queue_random_bytes(150, limit_reg);
    wait_drained();

    // Over-limit error, then bytes the halted decoder must drop
    case ($urandom_range(2, 0))
      0: begin
        write_limit(32'hFFFF_FFFF);
        big_len = {32'($urandom_range(32'hFFFF_FFFF, 1)), 32'($urandom)};
        queue_frame(1'($urandom), 3'($urandom), OP_TEXT, 1'($urandom), LEN_EXT64, big_len, 0);
      end
      1: begin
        lim = $urandom_range(65534, 0);
        write_limit(lim);
        big_len = {32'd0, 32'($urandom_range(65535, lim + 1))};
        queue_frame(1'($urandom), 3'($urandom), OP_PING, 1'($urandom), LEN_EXT16, big_len, 0);
      end
      default: begin
        lim = $urandom_range(124, 0);
        write_limit(lim);
        big_len = {32'd0, 32'($urandom_range(125, lim + 1))};
        queue_frame(1'($urandom), 3'($urandom), OP_CLOSE, 1'($urandom), LEN_SHORT, big_len, 0);
      end
    endcase
    repeat (20) add_byte(8'($urandom));
    wait_drained();

    repeat (END_SETTLE) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("websocket_frame_decoder test passed");
    end else begin
      $display("websocket_frame_decoder test failed");
    end
    $finish;
  end

endmodule
